/* rtl/core/pct_pkg.sv */
// ----------------------------------------------------------------------------
// pct_pkg: shared types and decode helpers for the percent escape decoder
// Holds the escape phase encoding, the result item and push bundles, and the
// hex pair decode used on the third byte of an escape.
// ----------------------------------------------------------------------------
package pct_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Result queue depth: room for two results while one more is held.
    localparam int QUEUE_DEPTH = 3;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,  // not inside an escape
        PH_PCT  = 2'd1,  // '%' seen
        PH_HELD = 2'd2   // '%' and one byte seen
    } phase_t;

    typedef struct packed {
        logic [7:0] chr;
        logic       fin;
    } res_t;

    // Results produced by one accepted item.
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == SPACE_CHAR) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Pair decode with number-parser quirks: leading blank or '+', leading
    // '-' (negated mod 256), single digit, else zero.
    function automatic logic [7:0] decode_pair(input logic [7:0] a,
                                               input logic [7:0] b);
        logic [3:0] va;
        logic [3:0] vb;
        logic [7:0] res;
        va  = hex_val(a);
        vb  = hex_val(b);
        res = 8'h00;
        if (is_hex(a)) begin
            res = is_hex(b) ? {va, vb} : {4'h0, va};
        end else if (is_blank(a) || a == PLUS_CHAR) begin
            res = is_hex(b) ? {4'h0, vb} : 8'h00;
        end else if (a == MINUS_CHAR) begin
            res = is_hex(b) ? (8'h00 - {4'h0, vb}) : 8'h00;
        end
        return res;
    endfunction

endpackage

/* rtl/core/pct_out_queue.sv */
// ----------------------------------------------------------------------------
// pct_out_queue: result queue of the percent escape decoder
// Shift queue that takes up to two results per cycle and hands one per cycle
// to the result channel while the receiver is ready.
// ----------------------------------------------------------------------------
module pct_out_queue #(
    parameter int Depth = pct_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  pct_pkg::push_t push,
    output logic           room_two,   // at least two free entries
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,    // [7:0] char_out
    output logic           m_tlast     // out_final
);

    localparam int CntW = $clog2(Depth + 1);

    pct_pkg::res_t  q_reg    [Depth];
    pct_pkg::res_t  q_next   [Depth];
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;
    logic [CntW-1:0] cnt_pop;
    logic            pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = q_reg[0].chr;
    assign m_tlast  = q_reg[0].fin;
    assign room_two = (cnt_reg <= CntW'(Depth - 2));

    always_comb begin
        cnt_pop = cnt_reg - CntW'(pop);
        for (int i = 0; i < Depth; i++) begin
            if (pop && i < Depth - 1) begin
                q_next[i] = q_reg[i + 1];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (push.n != 2'd0 && CntW'(i) == cnt_pop) begin
                q_next[i] = push.r0;
            end
            if (push.n == 2'd2 && CntW'(i) == cnt_pop + CntW'(1)) begin
                q_next[i] = push.r1;
            end
        end
        cnt_next = cnt_pop + CntW'(push.n);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < Depth; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CntW'(Depth))
        else $error("result queue count out of range");

    a_no_overflow : assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n != 2'd0) |-> (cnt_reg <= CntW'(Depth - 2)))
        else $error("results pushed without room");

    a_pop_only : assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push.n == 2'd0) |=> (cnt_reg == $past(cnt_reg) - CntW'(1)))
        else $error("queue count wrong after pop");
`endif

endmodule

/* rtl/core/percent_escape_decoder.sv */
// ----------------------------------------------------------------------------
// percent_escape_decoder: percent escape decoder, one byte per cycle while s_tready is high
// Turns '%' plus two bytes into one byte; other bytes pass through.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one encoded byte per item in s_tdata, s_tlast high on
//   the last byte of a string. Result channel m_*: decoded bytes, m_tlast on
//   the last decoded byte of the string.
//   A '%' and the byte after it produce nothing; the third byte produces the
//   decoded value. A string that ends on '%' or one byte after it gets the
//   raw bytes back ('%' then the final byte when two come out).
//   A result is queued when its item is accepted and leaves on m_* in order.
//   Throughput: one item per cycle while s_tready is high, set by the
//   combinational decode and the one-result-per-cycle output port. An
//   item that makes two results (cut-short escape) hands them out in turn.
//   A three-entry result queue parts the sides: s_tready stays high while at
//   least two entries are free, so an item is taken while one result waits.
//   If the receiver stalls, the queue fills and s_tready drops.
//   Reset (aresetn low, synchronous) empties the queue and leaves the escape.
// ----------------------------------------------------------------------------
module percent_escape_decoder #(
    parameter int QueueDepth = pct_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,   // is_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic       m_tlast    // out_final
);

    pct_pkg::phase_t phase_reg;
    pct_pkg::phase_t phase_next;
    logic [7:0]      held_reg;
    pct_pkg::push_t  push;
    logic            room_two;
    logic            s_acc;

    assign s_tready = room_two;
    assign s_acc    = s_tvalid && s_tready;

    // Next escape phase; a final byte always closes the string.
    always_comb begin
        phase_next = phase_reg;
        if (s_acc) begin
            if (s_tlast) begin
                phase_next = pct_pkg::PH_IDLE;
            end else begin
                unique case (phase_reg)
                    pct_pkg::PH_PCT:  phase_next = pct_pkg::PH_HELD;
                    pct_pkg::PH_HELD: phase_next = pct_pkg::PH_IDLE;
                    default: begin
                        phase_next = (s_tdata == pct_pkg::PCT_CHAR) ?
                                     pct_pkg::PH_PCT : pct_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Results of the item now on the input.
    always_comb begin
        push.n  = 2'd0;
        push.r0 = '{chr: s_tdata, fin: s_tlast};
        push.r1 = '{chr: s_tdata, fin: 1'b1};
        if (s_acc) begin
            unique case (phase_reg)
                pct_pkg::PH_PCT: begin
                    if (s_tlast) begin
                        // escape cut short: give back '%' and this byte
                        push.n  = 2'd2;
                        push.r0 = '{chr: pct_pkg::PCT_CHAR, fin: 1'b0};
                    end
                end
                pct_pkg::PH_HELD: begin
                    push.n      = 2'd1;
                    push.r0.chr = pct_pkg::decode_pair(held_reg, s_tdata);
                end
                default: begin
                    if (!(s_tdata == pct_pkg::PCT_CHAR && !s_tlast)) begin
                        push.n = 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pct_pkg::PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // First byte after '%'.
    always_ff @(posedge aclk) begin
        if (s_acc && phase_reg == pct_pkg::PH_PCT && !s_tlast) begin
            held_reg <= s_tdata;
        end
    end

    pct_out_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room_two (room_two),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_held_step : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && phase_reg == pct_pkg::PH_PCT && !s_tlast)
        |=> (phase_reg == pct_pkg::PH_HELD && held_reg == $past(s_tdata)))
        else $error("escape did not hold first byte");

    a_two_from_pct : assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n == 2'd2) |-> (phase_reg == pct_pkg::PH_PCT && s_tlast))
        else $error("two results outside a cut-short escape");

    a_final_closes : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (phase_reg == pct_pkg::PH_IDLE))
        else $error("escape open after final byte");
`endif

endmodule
